@@ hdl/edge_element_recognizer_macros.svh @@
// assertion helpers for the edge element recognizer
`ifndef EDGE_ELEMENT_RECOGNIZER_MACROS_SVH
`define EDGE_ELEMENT_RECOGNIZER_MACROS_SVH

// a property that must hold at every clock edge outside reset
`define EER_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// an implication checked from the next clock edge on
`define EER_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/eer_pkg.sv @@
package eer_pkg;

  localparam int unsigned KEY_BITS   = 10;
  localparam int unsigned ELEM_DEPTH = 256;
  localparam int unsigned ELEM_BITS  = $clog2(ELEM_DEPTH);
  localparam int unsigned COLOR_BITS = 32;
  localparam int unsigned LIST_MAX   = 32;
  localparam int unsigned STEP_BITS  = $clog2(LIST_MAX + 1);
  localparam int unsigned ID_BITS    = 16;
  localparam int unsigned FLAG_BITS  = 6;
  localparam int unsigned ELEM_W     = ID_BITS + FLAG_BITS + 4 * COLOR_BITS;
  localparam int unsigned CFG_BITS   = 10;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [1:0] MODE_SLOT  = 2'd0;
  localparam logic [1:0] MODE_ELEM  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SURF_MASK  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_MASK  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EDGE_SHIFT = 2'd2;

  localparam int unsigned FL_SURF_PRESENT = 0;
  localparam int unsigned FL_SURF_ABSENT  = 1;
  localparam int unsigned FL_EDGE_ABSENT  = 3;
  localparam int unsigned FL_LATCAP       = 4;
  localparam int unsigned FL_END          = 5;

  // one result word
  typedef struct packed {
    logic               last;
    logic               none_found;
    logic               match_latcap;
    logic [ID_BITS-1:0] match_id;
    logic [7:0]         match_index;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SLOT = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

@@ hdl/eer_out_buf.sv @@
module eer_out_buf
  import eer_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  logic    valid_q;
  result_t data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

@@ hdl/edge_element_recognizer.sv @@
// edge element recognizer
// s_axis carries write and query words; mode 0 loads a key slot, mode 1 an element
// entry (id, flags, four condition masks), mode 2 queries with a surface and an
// edge color. a write produces nothing; writes can follow back to back. a query
// forms a key, reads the slot memory, then reads the element memory one entry a
// cycle while no match waits on a blocked output, testing each entry as it
// returns; the walk ends at the list-end flag or after 32 entries.
// every emitted match (or one none word) leaves on m_axis, tlast on the final one.
// a one-word output register lets the walk run while a word waits; when the
// receiver stalls the walk holds once a further match is found. s_axis_tready is
// low during a query. the cfg port writes the key masks and shift; the user writes
// them only between queries, and the block itself does not enforce it. reset
// clears control state and the cfg registers; the tables hold garbage until written.
module edge_element_recognizer
  import eer_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]     cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // mode, index, slot_start, slot_filtered, elem_id, elem_flags, surf_present_mask,
  // surf_absent_mask, edge_present_mask, edge_absent_mask, surface_color,
  // edge_color (235 bits, padded to 240)
  input  logic [239:0]            s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // match_index, match_id, match_latcap, none_found (26 bits, padded to 32)
  output logic [31:0]             m_axis_tdata,
  output logic                    m_axis_tlast
);

  logic [1:0]            f_mode;
  logic [9:0]            f_index;
  logic [7:0]            f_start;
  logic                  f_filt;
  logic [ID_BITS-1:0]    f_id;
  logic [FLAG_BITS-1:0]  f_flags;
  logic [COLOR_BITS-1:0] f_sp, f_sa, f_ep, f_ea, f_sc, f_ec;
  assign f_mode  = s_axis_tdata[1:0];
  assign f_index = s_axis_tdata[11:2];
  assign f_start = s_axis_tdata[19:12];
  assign f_filt  = s_axis_tdata[20];
  assign f_id    = s_axis_tdata[36:21];
  assign f_flags = s_axis_tdata[42:37];
  assign f_sp    = s_axis_tdata[74:43];
  assign f_sa    = s_axis_tdata[106:75];
  assign f_ep    = s_axis_tdata[138:107];
  assign f_ea    = s_axis_tdata[170:139];
  assign f_sc    = s_axis_tdata[202:171];
  assign f_ec    = s_axis_tdata[234:203];

  logic [CFG_BITS-1:0] surf_mask_q, edge_mask_q;
  logic [3:0]          edge_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_mask_q  <= '0;
      edge_mask_q  <= '0;
      edge_shift_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SURF_MASK:  surf_mask_q  <= cfg_data_i;
        CFG_EDGE_MASK:  edge_mask_q  <= cfg_data_i;
        CFG_EDGE_SHIFT: edge_shift_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // memories: key slots and element entries (masks, flags, id in one word)
  logic [8:0]        slot_mem [1<<KEY_BITS];
  logic [ELEM_W-1:0] elem_mem [ELEM_DEPTH];

  state_e                state_q, state_d;
  logic [COLOR_BITS-1:0] sc_q, ec_q;
  logic [ELEM_BITS-1:0]  addr_q, addr_d;     // address being read
  logic [ELEM_BITS-1:0]  rd_addr_q;          // address of data on the read port
  logic                  rd_valid_q;
  logic                  filt_q;
  logic [STEP_BITS-1:0]  step_q;
  logic                  have_q;
  logic [ID_BITS-1:0]    last_id_q;
  logic                  pend_q;             // held match not yet known to be last
  result_t               pend_r_q;

  logic [8:0]                   slot_rd;
  logic [ELEM_W-1:0]            elem_rd;
  logic [ID_BITS+FLAG_BITS-1:0] info_rd;
  logic [COLOR_BITS-1:0]        sp_rd, sa_rd, ep_rd, ea_rd;
  assign {ea_rd, ep_rd, sa_rd, sp_rd, info_rd} = elem_rd;

  logic [KEY_BITS-1:0] key;
  logic [19:0]         edge_part;
  assign edge_part = {10'd0, f_ec[9:0] & edge_mask_q} << edge_shift_q;
  assign key = KEY_BITS'({10'd0, f_sc[9:0] & surf_mask_q}
                + ((edge_mask_q != '0) ? edge_part : 20'd0));

  logic acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;

  logic buf_ready, emit_valid;
  result_t emit_r;

  always_ff @(posedge clk_i) begin
    if (acc && f_mode == MODE_SLOT) slot_mem[f_index] <= {f_filt, f_start};
    if (acc && f_mode == MODE_ELEM) begin
      elem_mem[f_index[ELEM_BITS-1:0]] <= {f_ea, f_ep, f_sa, f_sp, f_flags, f_id};
    end
    slot_rd <= slot_mem[key];
  end

  // element read: the walk stalls (keeps address) while a new match waits on a blocked output
  logic hold;
  always_ff @(posedge clk_i) begin
    if (!hold) begin
      elem_rd <= elem_mem[addr_d];
    end
  end

  // evaluate returned entry
  logic [FLAG_BITS-1:0] fl;
  logic [ID_BITS-1:0]   rid;
  logic pass, take, ends;
  assign fl  = info_rd[ID_BITS +: FLAG_BITS];
  assign rid = info_rd[ID_BITS-1:0];
  always_comb begin
    pass = 1'b1;
    if (fl[3:0] != '0) begin
      if ((ec_q & ep_rd) != ep_rd) pass = 1'b0;
      if (fl[FL_SURF_PRESENT] && (sc_q & sp_rd) != sp_rd) pass = 1'b0;
      if (fl[FL_SURF_ABSENT] && (sc_q & sa_rd) != '0) pass = 1'b0;
      if (fl[FL_EDGE_ABSENT] && (ec_q & ea_rd) != '0) pass = 1'b0;
    end
  end
  assign take = !filt_q || (pass && (!have_q || rid != last_id_q || fl[FL_LATCAP]));
  assign ends = fl[FL_END] || (step_q == STEP_BITS'(LIST_MAX - 1));

  logic eval;
  assign eval = (state_q == ST_WALK) && rd_valid_q;
  // a new match pushes out the pending one, which needs the buffer
  assign hold = eval && take && pend_q && !buf_ready;

  always_comb begin
    emit_valid = 1'b0;
    emit_r     = pend_r_q;
    if (eval && take && pend_q) begin
      emit_valid = 1'b1;
    end else if (state_q == ST_DONE) begin
      emit_valid = 1'b1;
      if (pend_q) emit_r.last = 1'b1;
      else emit_r = '{last: 1'b1, none_found: 1'b1, match_latcap: 1'b0,
                      match_id: '0, match_index: '0};
    end
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      ST_IDLE: if (acc && f_mode == MODE_QUERY) state_d = ST_SLOT;
      ST_SLOT: begin
        addr_d  = slot_rd[ELEM_BITS-1:0];
        state_d = ST_WALK;
      end
      ST_WALK: if (!hold) begin
        if (eval && ends) state_d = ST_DONE;
        else addr_d = addr_q + 1'b1;
      end
      ST_DONE: if (buf_ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      addr_q     <= '0;
      rd_addr_q  <= '0;
      rd_valid_q <= 1'b0;
      step_q     <= '0;
      have_q     <= 1'b0;
      pend_q     <= 1'b0;
      filt_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (!hold) begin
        addr_q     <= addr_d;
        rd_addr_q  <= addr_d;
        rd_valid_q <= (state_q == ST_SLOT) || (state_q == ST_WALK && !(eval && ends));
      end
      if (state_q == ST_SLOT) begin
        filt_q <= slot_rd[8];
        step_q <= '0;
        have_q <= 1'b0;
        pend_q <= 1'b0;
      end else if (eval && !hold) begin
        step_q <= step_q + 1'b1;
        if (take) begin
          have_q <= 1'b1;
          pend_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sc_q <= f_sc;
      ec_q <= f_ec;
    end
    if (eval && !hold && take) begin
      last_id_q <= rid;
      pend_r_q  <= '{last: 1'b0, none_found: 1'b0, match_latcap: fl[FL_LATCAP],
                     match_id: rid, match_index: 8'(rd_addr_q)};
    end
  end

  result_t out_r;
  eer_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (emit_valid),
    .in_ready_o (buf_ready),
    .in_data_i  (emit_r),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_r)
  );
  assign m_axis_tdata = {6'd0, out_r.none_found, out_r.match_latcap, out_r.match_id,
                         out_r.match_index};
  assign m_axis_tlast = out_r.last;

`include "edge_element_recognizer_macros.svh"

  `EER_ASSERT(a_busy_no_accept, (state_q != ST_IDLE) -> !s_axis_tready, "accept during query")
  `EER_ASSERT(a_step_bound, step_q <= STEP_BITS'(LIST_MAX), "walk ran too long")
  `EER_ASSERT_NEXT(a_slot_to_walk, state_q == ST_SLOT, state_q == ST_WALK, "slot read skipped")
  `EER_ASSERT_NEXT(a_done_hold, state_q == ST_DONE && !buf_ready, state_q == ST_DONE,
                   "final word lost")

endmodule

@@ test/tb_edge_element_recognizer.sv @@
module tb_edge_element_recognizer;
  import eer_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]         match_index;
    logic [ID_BITS-1:0] match_id;
    logic               match_latcap;
    logic               none_found;
    logic               last;
  } match_t;

  class match_board;
    logic [8:0]            slot_mem [1024];
    bit                    slot_seen [1024];
    logic [ID_BITS-1:0]    id_mem [ELEM_DEPTH];
    logic [FLAG_BITS-1:0]  flag_mem [ELEM_DEPTH];
    logic [31:0]           sp_mem [ELEM_DEPTH];
    logic [31:0]           sa_mem [ELEM_DEPTH];
    logic [31:0]           ep_mem [ELEM_DEPTH];
    logic [31:0]           ea_mem [ELEM_DEPTH];
    logic [9:0]            surf_mask, edge_mask;
    logic [3:0]            edge_shift;
    match_t                pending [$];
    int                    errors;

    function void set_reg(logic [1:0] idx, logic [9:0] val);
      if (idx == CFG_SURF_MASK) surf_mask = val;
      else if (idx == CFG_EDGE_MASK) edge_mask = val;
      else if (idx == CFG_EDGE_SHIFT) edge_shift = val[3:0];
    endfunction

    function logic [9:0] key_of(logic [31:0] sc, logic [31:0] ec);
      logic [31:0] k;
      k = sc & {22'd0, surf_mask};
      if (edge_mask != 0) k = k + ((ec & {22'd0, edge_mask}) << edge_shift);
      return k[9:0];
    endfunction

    function bit cond_ok(int e, logic [31:0] sc, logic [31:0] ec);
      logic [5:0] f;
      f = flag_mem[e];
      if (f[3:0] == 0) return 1;
      if ((ec & ep_mem[e]) != ep_mem[e]) return 0;
      if (f[FL_SURF_PRESENT] && (sc & sp_mem[e]) != sp_mem[e]) return 0;
      if (f[FL_SURF_ABSENT] && (sc & sa_mem[e]) != 0) return 0;
      if (f[FL_EDGE_ABSENT] && (ec & ea_mem[e]) != 0) return 0;
      return 1;
    endfunction

    function void note_word(logic [239:0] d);
      logic [1:0] mode;
      logic [9:0] idx;
      logic [31:0] sc, ec;
      logic [8:0] slot;
      int e, n;
      bit have;
      logic [ID_BITS-1:0] prev;
      match_t m;
      mode = d[1:0];
      idx = d[11:2];
      if (mode == MODE_SLOT) begin
        slot_mem[idx] = d[20:12];
        slot_seen[idx] = 1;
      end else if (mode == MODE_ELEM) begin
        e = idx % ELEM_DEPTH;
        id_mem[e] = d[36:21];
        flag_mem[e] = d[42:37];
        sp_mem[e] = d[74:43];
        sa_mem[e] = d[106:75];
        ep_mem[e] = d[138:107];
        ea_mem[e] = d[170:139];
      end else if (mode == MODE_QUERY) begin
        sc = d[202:171];
        ec = d[234:203];
        slot = slot_mem[key_of(sc, ec)];
        e = slot[7:0];
        n = 0;
        have = 0;
        prev = 0;
        for (int s = 0; s < LIST_MAX; s++) begin
          if (!slot[8] || (cond_ok(e, sc, ec) &&
              (!have || id_mem[e] != prev || flag_mem[e][FL_LATCAP]))) begin
            have = 1;
            prev = id_mem[e];
            m = '{e[7:0], id_mem[e], flag_mem[e][FL_LATCAP], 1'b0, 1'b0};
            pending.push_back(m);
            n++;
          end
          if (flag_mem[e][FL_END]) break;
          e = (e + 1) % ELEM_DEPTH;
        end
        if (n == 0) pending.push_back('{8'd0, 16'd0, 1'b0, 1'b1, 1'b1});
        else pending[pending.size()-1].last = 1;
      end
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_word(logic [31:0] d, logic lst);
      match_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %h", d));
        return;
      end
      want = pending.pop_front();
      if (d[7:0] !== want.match_index)
        report($sformatf("index %0d want %0d", d[7:0], want.match_index));
      if (d[23:8] !== want.match_id)
        report($sformatf("id %0d want %0d", d[23:8], want.match_id));
      if (d[24] !== want.match_latcap) report("latcap");
      if (d[25] !== want.none_found) report("none_found");
      if (lst !== want.last) report("tlast");
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [239:0] s_axis_tdata = '0;
  logic m_axis_tvalid, m_axis_tready = 0, m_axis_tlast;
  logic [31:0] m_axis_tdata;

  match_board board = new();
  int stall_mode = 0;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  edge_element_recognizer i_dut (.*);

  // receiver: stall pattern changes over the run
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata, m_axis_tlast);
    case (stall_mode)
      0: m_axis_tready <= 1;
      1: m_axis_tready <= ($urandom_range(3) != 0);
      default: m_axis_tready <= ($urandom_range(3) == 0);
    endcase
  end

  always @(posedge clk_i) if ($urandom_range(63) == 0) stall_mode <= $urandom_range(2);

  task automatic send(logic [239:0] d);
    s_axis_tdata <= d;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(d);
  endtask

  task automatic gap();
    int g;
    g = ($urandom_range(3) == 0) ? $urandom_range(6) : 0;
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [239:0] slot_word(int idx, int start, bit filt);
    logic [239:0] d;
    d = '0;
    d[1:0] = MODE_SLOT;
    d[11:2] = 10'(idx);
    d[19:12] = 8'(start);
    d[20] = filt;
    return d;
  endfunction

  function automatic logic [239:0] elem_word(int idx, logic [15:0] id, logic [5:0] fl,
      logic [31:0] sp, logic [31:0] sa, logic [31:0] ep, logic [31:0] ea);
    logic [239:0] d;
    d = '0;
    d[1:0] = MODE_ELEM;
    d[11:2] = 10'(idx);
    d[36:21] = id;
    d[42:37] = fl;
    d[74:43] = sp;
    d[106:75] = sa;
    d[138:107] = ep;
    d[170:139] = ea;
    return d;
  endfunction

  function automatic logic [239:0] query_word(logic [31:0] sc, logic [31:0] ec);
    logic [239:0] d;
    d = '0;
    d[1:0] = MODE_QUERY;
    d[202:171] = sc;
    d[234:203] = ec;
    return d;
  endfunction

  function automatic logic [31:0] rnd_mask();
    case ($urandom_range(3))
      0: return 0;
      1: return 32'hffff_ffff;
      2: return 32'd1 << $urandom_range(31);
      default: return $urandom() & $urandom() & $urandom();
    endcase
  endfunction

  // a query only ever lands on a written slot; slot starts stay in the written entries
  task automatic query(logic [31:0] sc, logic [31:0] ec);
    logic [9:0] k;
    k = board.key_of(sc, ec);
    if (!board.slot_seen[k]) send(slot_word(k, $urandom_range(9), $urandom_range(1)));
    send(query_word(sc, ec));
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [9:0] sm, logic [9:0] em, logic [3:0] sh);
    drain();
    cfg_we_i <= 1;
    cfg_index_i <= CFG_SURF_MASK; cfg_data_i <= sm; @(posedge clk_i);
    cfg_index_i <= CFG_EDGE_MASK; cfg_data_i <= em; @(posedge clk_i);
    cfg_index_i <= CFG_EDGE_SHIFT; cfg_data_i <= sh; @(posedge clk_i);
    cfg_we_i <= 0;
    board.set_reg(CFG_SURF_MASK, sm);
    board.set_reg(CFG_EDGE_MASK, em);
    board.set_reg(CFG_EDGE_SHIFT, sh);
  endtask

  initial begin
    #10_000_000;
    $display("FAIL edge_element_recognizer");
    $finish;
  end

  initial begin
    logic [5:0] fl;
    logic [9:0] sm, em;
    logic [239:0] w;
    board.errors = 0;
    board.set_reg(CFG_SURF_MASK, 0);
    board.set_reg(CFG_EDGE_MASK, 0);
    board.set_reg(CFG_EDGE_SHIFT, 0);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // entries 0..9 here, 10..41 below; walks from random slots stay inside them
    for (int i = 0; i < 10; i++) begin
      fl = $urandom_range(63);
      if ($urandom_range(2) == 0) fl[FL_END] = 0;
      send(elem_word(i, 16'($urandom_range(3)), fl, rnd_mask(), rnd_mask(), rnd_mask(),
                     rnd_mask()));
    end
    // directed: key zero, wrapped writes, walk past end, missing end, dedup
    send(slot_word(0, 255, 0));
    send(elem_word(255, 16'hffff, 6'b010000, '1, '1, '1, '1));
    send(elem_word(256, 16'h0000, 6'b100000, 0, 0, 0, 0)); // wraps to entry 0
    query(0, 0);
    send(slot_word(1, 250, 1));
    for (int i = 250; i < 256; i++) send(elem_word(i, 7, 6'b000100, 0, 0, 0, 0));
    send(elem_word(0, 7, 6'b110000, 0, 0, 0, 0));
    send(slot_word(2, 10, 1));
    for (int i = 10; i < 42; i++) send(elem_word(i, 16'(i), 6'b001111, 1, 2, 4, 8));
    send(slot_word(3, 10, 0));
    set_cfg(10'h3ff, 0, 0);
    query(1, 32'hffff_ffff);
    query(2, 4);
    query(2, 0);
    query(3, 0);
    query(32'hffff_ffff, 32'hffff_ffff);
    w = '1;
    w[1:0] = 2'd3;
    send(w);
    set_cfg(10'h3ff, 10'h3ff, 9);
    query($urandom(), $urandom());
    set_cfg(10'h007, 10'h003, 3);
    // random: mostly queries, some rewrites
    for (int n = 0; n < 160; n++) begin
      if (n == 55) set_cfg(0, 10'h01f, 0);
      if (n == 110) begin
        sm = 10'(1 << $urandom_range(9)) | 10'(1 << $urandom_range(9));
        em = 10'(1 << $urandom_range(9));
        set_cfg(sm, em, 4'($urandom_range(9)));
      end
      case ($urandom_range(9))
        0: send(slot_word($urandom_range(1023), $urandom_range(9), $urandom_range(1)));
        1: begin
          fl = $urandom_range(63);
          send(elem_word($urandom_range(41) + 256 * $urandom_range(3),
                         $urandom_range(3) == 0 ? 16'($urandom()) : 16'd5,
                         fl, rnd_mask(), rnd_mask(), rnd_mask(), rnd_mask()));
        end
        default: query($urandom(), $urandom());
      endcase
      gap();
    end
    drain();
    if (board.errors == 0) $display("PASS edge_element_recognizer");
    else $display("FAIL edge_element_recognizer");
    $finish;
  end
endmodule
